// ===== hw/rtl/iteration_count_colormap_core_macros.svh =====
// ----------------------------------------------------------------------------
// Colormap assertion macros
// Concurrent assertion wrappers, dropped entirely for synthesis.
// ----------------------------------------------------------------------------
`ifndef ITERATION_COUNT_COLORMAP_CORE_MACROS_SVH
`define ITERATION_COUNT_COLORMAP_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ICC_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("colormap assertion failed");

// next-cycle implication
`define ICC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("colormap assertion failed");

`else

`define ICC_ASSERT_IMPL(label, clk, rst, pre, post)
`define ICC_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== hw/rtl/icc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colormap package
// Widths, palette constants, register indexes and small helpers.
// ----------------------------------------------------------------------------
package icc_pkg;

  // iteration range; ITER_LIMIT is a power of two, so the divide is a shift
  localparam int ITER_LIMIT = 256;
  localparam int ITER_W   = $clog2(ITER_LIMIT);  // width of an in-range count
  localparam int CNT_W    = 9;    // input count width

  // hue position: count * 6 * 2^16 / ITER_LIMIT, 16 fraction bits
  localparam int FRAC_W    = 16;
  localparam int HUE_W     = 19;
  localparam int HUE_SCALE = 6 * 65536;
  localparam int HUE_PROD_W = ITER_W + HUE_W;

  // grey-mode channel scales and Q16 luma weights
  localparam int K_RED    = 200;
  localparam int K_GREEN  = 150;
  localparam int K_BLUE   = 255;
  localparam int LUMA_R   = 19595;
  localparam int LUMA_G   = 38470;
  localparam int LUMA_B   = 7471;

  localparam logic [31:0] INSIDE_RAINBOW = 32'h0038A8FF;
  localparam logic [31:0] INSIDE_GREY    = 32'hFFFFFFFF;
  localparam logic [7:0]  GREY_ALPHA     = 8'hFF;
  localparam logic [7:0]  CHAN_FULL      = 8'hFF;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GREY_MODE   = 3'd0,
    REG_ALPHA_VALUE = 3'd1,
    REG_RED_GAIN    = 3'd2,
    REG_GREEN_GAIN  = 3'd3,
    REG_BLUE_GAIN   = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] ALPHA_RESET = 8'hFF;
  localparam logic [7:0] GAIN_RESET  = 8'd1;

  // v mod 255 for v < 65026: byte sum then one conditional subtract
  function automatic logic [7:0] mod255(input logic [15:0] v);
    logic [8:0] s;
    s = 9'(v[15:8]) + 9'(v[7:0]);
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

  // ramp byte of one hue sector; odd sectors fall
  function automatic logic [7:0] hue_ramp(input logic odd, input logic [FRAC_W-1:0] f);
    logic [FRAC_W:0] t;
    logic [23:0]     prod;
    t    = odd ? (17'h10000 - 17'(f)) : 17'(f);
    prod = 24'(t) * 24'd255;
    return prod[23:16];
  endfunction

endpackage

// ===== hw/rtl/iteration_count_colormap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iteration count colormap core
// Maps an escape-iteration count to a packed RGBA pixel (rainbow or grey).
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  in       | in_valid / in_stall | iteration_count [8:0]
//  out      | out_valid/out_stall | pixel_rgba [31:0] (R,G,B,A high->low)
//  cfg      | cfg_valid/cfg_ready | cfg_index [2:0], cfg_data [7:0]
//
// Four register stages, one count per cycle sustained while out is not
// stalled; pixel_rgba is registered in the fourth stage. Depth is set by
// the gain, K and luma multiplies. Each stage holds its own valid bit and
// fills its bubbles, so a stall on out backs up stage by stage; in_stall
// rises only when every stage is full and out is stalled. Synchronous reset
// clears valid bits and the configuration registers to their defaults.
// cfg_ready is always high; writes are expected only while the pipe is
// empty.

`include "iteration_count_colormap_core_macros.svh"

module iteration_count_colormap_core (
  input  logic                               clk,
  input  logic                               rst,
  // count input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [icc_pkg::CNT_W-1:0]          iteration_count,
  // pixel output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        pixel_rgba,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [icc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       grey_mode;
  logic [7:0] alpha_value;
  logic [7:0] red_gain;
  logic [7:0] green_gain;
  logic [7:0] blue_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_mode   <= 1'b0;
      alpha_value <= icc_pkg::ALPHA_RESET;
      red_gain    <= icc_pkg::GAIN_RESET;
      green_gain  <= icc_pkg::GAIN_RESET;
      blue_gain   <= icc_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icc_pkg::REG_GREY_MODE:   grey_mode   <= cfg_data[0];
        icc_pkg::REG_ALPHA_VALUE: alpha_value <= cfg_data;
        icc_pkg::REG_RED_GAIN:    red_gain    <= cfg_data;
        icc_pkg::REG_GREEN_GAIN:  green_gain  <= cfg_data;
        icc_pkg::REG_BLUE_GAIN:   blue_gain   <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign s3_ready  = !s3_valid  || out_ready;
  assign s2_ready  = !s2_valid  || s3_ready;
  assign s1_ready  = !s1_valid  || s2_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid  <= in_valid;
      if (s2_ready)  s2_valid  <= s1_valid;
      if (s3_ready)  s3_valid  <= s2_valid;
      if (out_ready) out_valid <= s3_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: inside-set test, gain * count, hue position
  // --------------------------------------------------------------------------
  logic [icc_pkg::ITER_W-1:0]      cnt_lo;
  logic                            cnt_inside;
  logic [icc_pkg::HUE_PROD_W-1:0]  hue_scaled;
  logic [icc_pkg::HUE_W-1:0]       hue_pos;

  assign cnt_lo     = iteration_count[icc_pkg::ITER_W-1:0];
  assign cnt_inside = 32'(iteration_count) >= 32'(icc_pkg::ITER_LIMIT);
  assign hue_scaled = icc_pkg::HUE_PROD_W'(cnt_lo)
                    * icc_pkg::HUE_PROD_W'(icc_pkg::HUE_SCALE);
  // divide by ITER_LIMIT (power of two)
  assign hue_pos    = icc_pkg::HUE_W'(hue_scaled >> icc_pkg::ITER_W);

  logic                         s1_inside;
  logic [15:0]                  s1_pr, s1_pg, s1_pb;
  logic [2:0]                   s1_sector;
  logic [icc_pkg::FRAC_W-1:0]   s1_frac;

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_inside <= cnt_inside;
      s1_pr     <= 16'(red_gain)   * 16'(cnt_lo);
      s1_pg     <= 16'(green_gain) * 16'(cnt_lo);
      s1_pb     <= 16'(blue_gain)  * 16'(cnt_lo);
      s1_sector <= hue_pos[icc_pkg::HUE_W-1:icc_pkg::FRAC_W];
      s1_frac   <= hue_pos[icc_pkg::FRAC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by K, divide by ITER_LIMIT, mod 255; hue ramp byte
  // --------------------------------------------------------------------------
  logic [23:0] kr_prod, kg_prod, kb_prod;

  assign kr_prod = 24'(s1_pr) * 24'(icc_pkg::K_RED);
  assign kg_prod = 24'(s1_pg) * 24'(icc_pkg::K_GREEN);
  assign kb_prod = 24'(s1_pb) * 24'(icc_pkg::K_BLUE);

  logic       s2_inside;
  logic [7:0] s2_r, s2_g, s2_b;
  logic [2:0] s2_sector;
  logic [7:0] s2_x;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_inside <= s1_inside;
      s2_r      <= icc_pkg::mod255(16'(kr_prod >> icc_pkg::ITER_W));
      s2_g      <= icc_pkg::mod255(16'(kg_prod >> icc_pkg::ITER_W));
      s2_b      <= icc_pkg::mod255(16'(kb_prod >> icc_pkg::ITER_W));
      s2_sector <= s1_sector;
      s2_x      <= icc_pkg::hue_ramp(s1_sector[0], s1_frac);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: luma weight products; rainbow sector mapping
  // --------------------------------------------------------------------------
  logic [23:0] rgb_rainbow;

  always_comb begin
    case (s2_sector)
      3'd0:    rgb_rainbow = {icc_pkg::CHAN_FULL, s2_x, 8'h00};
      3'd1:    rgb_rainbow = {s2_x, icc_pkg::CHAN_FULL, 8'h00};
      3'd2:    rgb_rainbow = {8'h00, icc_pkg::CHAN_FULL, s2_x};
      3'd3:    rgb_rainbow = {8'h00, s2_x, icc_pkg::CHAN_FULL};
      3'd4:    rgb_rainbow = {s2_x, 8'h00, icc_pkg::CHAN_FULL};
      default: rgb_rainbow = {icc_pkg::CHAN_FULL, 8'h00, s2_x};
    endcase
  end

  logic        s3_inside;
  logic [23:0] s3_wr, s3_wg, s3_wb;
  logic [23:0] s3_rgb;

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_inside <= s2_inside;
      s3_wr     <= 24'(s2_r) * 24'(icc_pkg::LUMA_R);
      s3_wg     <= 24'(s2_g) * 24'(icc_pkg::LUMA_G);
      s3_wb     <= 24'(s2_b) * 24'(icc_pkg::LUMA_B);
      s3_rgb    <= rgb_rainbow;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: luma sum and pixel select into the output register
  // --------------------------------------------------------------------------
  logic [24:0] luma_sum;
  logic [7:0]  luma;
  logic [31:0] pixel_next;

  assign luma_sum = 25'(s3_wr) + 25'(s3_wg) + 25'(s3_wb);
  assign luma     = 8'(luma_sum >> 16);

  always_comb begin
    if (s3_inside) begin
      pixel_next = grey_mode ? icc_pkg::INSIDE_GREY : icc_pkg::INSIDE_RAINBOW;
    end else if (grey_mode) begin
      pixel_next = {luma, luma, luma, icc_pkg::GREY_ALPHA};
    end else begin
      pixel_next = {s3_rgb, alpha_value};
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      pixel_rgba <= pixel_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input back-pressure only when the whole pipe is full
  `ICC_ASSERT_IMPL(a_stall_only_full, clk, rst, in_stall, s1_valid && s2_valid && s3_valid && out_valid)
  // reduced grey channels are below 255
  `ICC_ASSERT_IMPL(a_mod255_range, clk, rst, s2_valid, s2_r != 8'hFF && s2_g != 8'hFF && s2_b != 8'hFF)
  // fully saturated hue: one channel is always full
  `ICC_ASSERT_IMPL(a_hue_has_full, clk, rst, s3_valid && !s3_inside, s3_rgb[23:16] == 8'hFF || s3_rgb[15:8] == 8'hFF || s3_rgb[7:0] == 8'hFF)

endmodule

// ===== tb/iteration_count_colormap_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iteration count colormap core testbench
// Drives escape-iteration counts through the core under random valid/stall
// gaps and register settings. Each pixel is checked against a local predictor
// of the rainbow, grey and inside-set palettes.
// ----------------------------------------------------------------------------
module iteration_count_colormap_core_tb;

  localparam int ITER_LIMIT = icc_pkg::ITER_LIMIT;
  localparam int CNT_W      = icc_pkg::CNT_W;
  localparam int CFG_IDX_W  = icc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = icc_pkg::CFG_DATA_W;

  // cycles with no transfer on any channel before the run is declared hung
  localparam int STALL_LIMIT  = 5000;
  // cycles to linger after the last pixel
  localparam int DRAIN_CYCLES = 16;
  // register indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_BLOCKS    = 5;
  localparam int ITEMS_PER_BLOCK  = 47;
  localparam int HOLDOFF_CYCLES   = 150;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [CNT_W-1:0]      iteration_count = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [31:0]           pixel_rgba;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  // predictor copy of the register file, reset values
  logic       cfg_grey       = 1'b0;
  logic [7:0] cfg_alpha      = 8'hFF;
  logic [7:0] cfg_red_gain   = 8'd1;
  logic [7:0] cfg_green_gain = 8'd1;
  logic [7:0] cfg_blue_gain  = 8'd1;

  logic [31:0] pending_pixels[$];   // expected pixels, oldest first
  int          mismatches    = 0;
  int          send_idle_pct = 0;     // chance per cycle that the sender idles
  int          recv_idle_pct = 0;     // chance per cycle that the sink stalls
  int          holdoff_left  = 0;     // forced sink stall, counted down per cycle
  int          quiet_cycles  = 0;

  iteration_count_colormap_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .iteration_count (iteration_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .pixel_rgba      (pixel_rgba),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Pixel for one count under the current register copy.
  function automatic logic [31:0] colormap_pixel(input logic [CNT_W-1:0] count);
    logic [31:0]     hue_pos;
    logic [31:0]     frac;
    logic [31:0]     ramp;
    logic [2:0]      sector;
    logic [7:0]      r, g, b, y;
    longint unsigned rc, gc, bc, luma;
    // inside the set: fixed colour per palette
    if (count >= CNT_W'(ITER_LIMIT)) begin
      return cfg_grey ? 32'hFFFFFFFF : 32'h0038A8FF;
    end
    if (cfg_grey) begin
      // exact integer scale, then wrap mod 255 per channel
      rc   = (64'(cfg_red_gain) * 64'(count) * 64'd200 / 64'(ITER_LIMIT)) % 64'd255;
      gc   = (64'(cfg_green_gain) * 64'(count) * 64'd150 / 64'(ITER_LIMIT)) % 64'd255;
      bc   = (64'(cfg_blue_gain) * 64'(count) * 64'd255 / 64'(ITER_LIMIT)) % 64'd255;
      luma = (64'd19595 * rc + 64'd38470 * gc + 64'd7471 * bc) >> 16;
      y    = 8'(luma);
      return {y, y, y, 8'hFF};
    end
    // hue position in Q16: sector in the integer part, ramp from the fraction
    hue_pos = 32'(count) * 32'd393216 / 32'(ITER_LIMIT);
    sector  = 3'(hue_pos >> 16);
    frac    = hue_pos & 32'h0000FFFF;
    ramp    = sector[0] ? (((32'h10000 - frac) * 32'd255) >> 16)
                        : ((frac * 32'd255) >> 16);
    case (sector)
      3'd0: begin r = 8'hFF;      g = 8'(ramp); b = 8'h00;      end
      3'd1: begin r = 8'(ramp);   g = 8'hFF;    b = 8'h00;      end
      3'd2: begin r = 8'h00;      g = 8'hFF;    b = 8'(ramp);   end
      3'd3: begin r = 8'h00;      g = 8'(ramp); b = 8'hFF;      end
      3'd4: begin r = 8'(ramp);   g = 8'h00;    b = 8'hFF;      end
      default: begin r = 8'hFF;   g = 8'h00;    b = 8'(ramp);   end
    endcase
    return {r, g, b, cfg_alpha};
  endfunction

  // --------------------------------------------------------------------------
  // Sink side: random stall plus an optional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected %08h got %08h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // Pixel checker: every out transfer pops the oldest expectation.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with no count pending", 32'h0, pixel_rgba);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_rgba !== want) begin
          report_mismatch("pixel_rgba", want, pixel_rgba);
        end
      end
    end
  end

  // Watchdog: quits when nothing has moved on any channel for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("iteration_count_colormap_core_tb failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left at a rising edge
  // --------------------------------------------------------------------------
  // One count transfer; the expected pixel is queued when it is accepted.
  task automatic send_count(input logic [CNT_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    iteration_count <= count;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_pixels.push_back(colormap_pixel(count));
  endtask

  // Drop valid and wait until every expected pixel has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_pixels.size() != 0);
  endtask

  // Register write; only called with the pipe empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      icc_pkg::REG_GREY_MODE:   cfg_grey       = data[0];
      icc_pkg::REG_ALPHA_VALUE: cfg_alpha      = data;
      icc_pkg::REG_RED_GAIN:    cfg_red_gain   = data;
      icc_pkg::REG_GREEN_GAIN:  cfg_green_gain = data;
      icc_pkg::REG_BLUE_GAIN:   cfg_blue_gain  = data;
      default: ;  // unmapped index, dropped
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Byte biased toward the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly in-range counts, some inside-set, some with the top bit over range.
  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 88) begin
      return CNT_W'($urandom_range(ITER_LIMIT - 1));
    end else if (roll < 94) begin
      return CNT_W'(ITER_LIMIT);
    end else begin
      return CNT_W'($urandom_range(511, ITER_LIMIT + 1));
    end
  endfunction

  task automatic randomize_regs();
    write_reg(icc_pkg::REG_GREY_MODE,   8'($urandom_range(255)));
    write_reg(icc_pkg::REG_ALPHA_VALUE, pick_byte());
    write_reg(icc_pkg::REG_RED_GAIN,    pick_byte());
    write_reg(icc_pkg::REG_GREEN_GAIN,  pick_byte());
    write_reg(icc_pkg::REG_BLUE_GAIN,   pick_byte());
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), pick_byte());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset palette: rainbow sector edges, Q16 fraction of zero at the
  // odd-sector start, and the inside-set colour including over-range counts.
  task automatic test_rainbow_sectors();
    logic [CNT_W-1:0] edges[$];
    edges = '{9'd0, 9'd1, 9'd42, 9'd43, 9'd85, 9'd86, 9'd128, 9'd170,
              9'd171, 9'd213, 9'd255, 9'd256, 9'd257, 9'd511};
    foreach (edges[i]) begin
      send_count(edges[i]);
    end
    wait_drained();
  endtask

  // Grey palette with zero and full gains, mod-255 wrap and white inside set.
  task automatic test_grey_palette();
    write_reg(icc_pkg::REG_GREY_MODE,   8'hFF);   // only bit 0 is kept
    write_reg(icc_pkg::REG_ALPHA_VALUE, 8'h00);   // grey alpha ignores this
    send_count(9'd0);
    send_count(9'd255);
    send_count(9'd256);
    wait_drained();
    write_reg(icc_pkg::REG_RED_GAIN,   8'hFF);
    write_reg(icc_pkg::REG_GREEN_GAIN, 8'hFF);
    write_reg(icc_pkg::REG_BLUE_GAIN,  8'hFF);
    send_count(9'd255);
    send_count(9'd128);
    wait_drained();
    write_reg(icc_pkg::REG_RED_GAIN,   8'h00);
    write_reg(icc_pkg::REG_BLUE_GAIN,  8'h00);
    send_count(9'd200);
    send_count(9'd400);
    wait_drained();
  endtask

  // Writes to unmapped indexes must leave the palette alone.
  task automatic test_unmapped_index();
    write_reg(icc_pkg::REG_GREY_MODE,   8'hFE);   // bit 0 clear: rainbow
    write_reg(icc_pkg::REG_ALPHA_VALUE, 8'h5A);
    for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++) begin
      write_reg(CFG_IDX_W'(idx), 8'hFF);
    end
    send_count(9'd100);
    send_count(9'd300);
    wait_drained();
  endtask

  // Sink holds off for a long stretch while counts keep coming, so the
  // pipe fills and in_stall backs up to the sender.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    holdoff_left  = HOLDOFF_CYCLES;
    repeat (40) begin
      send_count(pick_count());
    end
    wait_drained();
  endtask

  // Sender pauses until the pipe has emptied, then resumes.
  task automatic test_sender_pause();
    repeat (3) begin
      repeat (12) begin
        send_count(pick_count());
      end
      wait_drained();
    end
  endtask

  // Random counts under random registers, one idle profile per call.
  task automatic test_random_stream(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_BLOCKS) begin
      randomize_regs();
      repeat (ITEMS_PER_BLOCK) begin
        send_count(pick_count());
      end
      wait_drained();
    end
  endtask

  initial begin
    send_idle_pct = 17;
    recv_idle_pct = 78;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rainbow_sectors();
    test_grey_palette();
    test_unmapped_index();
    test_random_stream(17, 78);
    test_output_holdoff();
    test_random_stream(78, 17);
    test_sender_pause();
    test_random_stream(0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    // anything still queued here never came out
    foreach (pending_pixels[i]) begin
      report_mismatch("pixel never produced", pending_pixels[i], 32'h0);
    end
    if (mismatches == 0) begin
      $display("iteration_count_colormap_core_tb passed");
    end else begin
      $display("iteration_count_colormap_core_tb failed");
    end
    $finish;
  end

endmodule
